// ----- hdl/imu6lp_pkg.sv -----
// Shared types, constants, microcode ROM and saturation helpers for the IMU conditioning block.
`timescale 1ns / 1ps
package imu6lp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int RAW_BITS_DEF  = 16;

  localparam int NUM_AXES   = 6;
  localparam int AXIS_W     = 3;
  localparam int STEP_W     = 4;
  localparam int CNT_W      = 16;
  localparam int OUT_W      = 32;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DELAY_W    = 40;
  localparam int P0S_W      = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [AXIS_W-1:0] NUM_ACCEL = AXIS_W'(3);
  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

  localparam logic [31:0] ACCEL_SCALE_RST = 32'd2568390;
  localparam logic [31:0] GYRO_SCALE_RST  = 32'd262078927;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_B0     = 3'd0,
    REG_COEF_A1     = 3'd1,
    REG_COEF_A2     = 3'd2,
    REG_ACCEL_SCALE = 3'd3,
    REG_GYRO_SCALE  = 3'd4,
    REG_MODE        = 3'd5,
    REG_GYRO_BIAS   = 3'd6,
    REG_ACCEL_GAIN  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic        [30:0] coef_b0;
    logic signed [31:0] coef_a1;
    logic signed [31:0] coef_a2;
    logic        [31:0] accel_scale;
    logic        [31:0] gyro_scale;
    logic        [1:0]  mode;
    logic        [47:0] gyro_bias;
    logic        [47:0] accel_gain;
  } cfg_t;

  localparam int MODE_FILT = 0;
  localparam int MODE_CAL  = 1;

  typedef enum logic [2:0] {
    A_CNT  = 3'd0,
    A_B0   = 3'd1,
    A_A1   = 3'd2,
    A_A2   = 3'd3,
    A_GAIN = 3'd4
  } a_sel_t;

  typedef enum logic {
    B_SCALE = 1'b0,
    B_V     = 1'b1
  } b_sel_t;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_LOAD_V   = 4'd1,
    OP_FILT_Y   = 4'd2,
    OP_FILT_F1  = 4'd3,
    OP_FILT_F2  = 4'd4,
    OP_CAL_GYRO = 4'd5,
    OP_CAL_ACC  = 4'd6,
    OP_STORE    = 4'd7,
    OP_PUBLISH  = 4'd8
  } dp_op_t;

  typedef enum logic [2:0] {
    J_NONE      = 3'd0,
    J_NO_FILT   = 3'd1,
    J_NO_CAL    = 3'd2,
    J_GYRO      = 3'd3,
    J_ALWAYS    = 3'd4,
    J_MORE_AXES = 3'd5
  } jmp_t;

  typedef struct packed {
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    logic              mul_en;
    dp_op_t            op;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    ucode_t            uc;
    logic [AXIS_W-1:0] axis;
    logic              capture;
    logic              publish;
  } ctrl_t;

  localparam logic [STEP_W-1:0] ST_SCALE    = 4'd0;
  localparam logic [STEP_W-1:0] ST_LOAD     = 4'd1;
  localparam logic [STEP_W-1:0] ST_MUL_B0   = 4'd2;
  localparam logic [STEP_W-1:0] ST_FILT_Y   = 4'd3;
  localparam logic [STEP_W-1:0] ST_MUL_A1   = 4'd4;
  localparam logic [STEP_W-1:0] ST_FILT_F1  = 4'd5;
  localparam logic [STEP_W-1:0] ST_FILT_F2  = 4'd6;
  localparam logic [STEP_W-1:0] ST_CAL_CHK  = 4'd7;
  localparam logic [STEP_W-1:0] ST_MUL_GAIN = 4'd8;
  localparam logic [STEP_W-1:0] ST_CAL_ACC  = 4'd9;
  localparam logic [STEP_W-1:0] ST_CAL_GYRO = 4'd10;
  localparam logic [STEP_W-1:0] ST_STORE    = 4'd11;
  localparam logic [STEP_W-1:0] ST_PUBLISH  = 4'd12;

  localparam ucode_t UC_IDLE = '{A_CNT, B_SCALE, 1'b0, OP_NOP, J_NONE, ST_SCALE};

  // Per-axis program; a multiply issued in one step is consumed by the next.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t r;
    r = UC_IDLE;
    case (step)
      ST_SCALE: begin
        r.a_sel = A_CNT; r.b_sel = B_SCALE; r.mul_en = 1'b1;
      end
      ST_LOAD: begin
        r.op = OP_LOAD_V; r.jmp = J_NO_FILT; r.target = ST_CAL_CHK;
      end
      ST_MUL_B0: begin
        r.a_sel = A_B0; r.b_sel = B_V; r.mul_en = 1'b1;
      end
      ST_FILT_Y: begin
        r.op = OP_FILT_Y;
      end
      ST_MUL_A1: begin
        r.a_sel = A_A1; r.b_sel = B_V; r.mul_en = 1'b1;
      end
      ST_FILT_F1: begin
        r.op = OP_FILT_F1; r.a_sel = A_A2; r.b_sel = B_V; r.mul_en = 1'b1;
      end
      ST_FILT_F2: begin
        r.op = OP_FILT_F2;
      end
      ST_CAL_CHK: begin
        r.jmp = J_NO_CAL; r.target = ST_STORE;
      end
      ST_MUL_GAIN: begin
        r.a_sel = A_GAIN; r.b_sel = B_V; r.mul_en = 1'b1;
        r.jmp = J_GYRO; r.target = ST_CAL_GYRO;
      end
      ST_CAL_ACC: begin
        r.op = OP_CAL_ACC; r.jmp = J_ALWAYS; r.target = ST_STORE;
      end
      ST_CAL_GYRO: begin
        r.op = OP_CAL_GYRO;
      end
      ST_STORE: begin
        r.op = OP_STORE; r.jmp = J_MORE_AXES; r.target = ST_SCALE;
      end
      ST_PUBLISH: begin
        r.op = OP_PUBLISH;
      end
      default: r = UC_IDLE;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
    logic [PROD_W-32:0] hi;
    logic signed [31:0] r;
    hi = x[PROD_W-1:31];
    if ((&hi) || !(|hi)) r = x[31:0];
    else if (x[PROD_W-1]) r = {1'b1, 31'b0};
    else r = {1'b0, {31{1'b1}}};
    return r;
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat40(input logic signed [PROD_W-1:0] x);
    logic [PROD_W-DELAY_W:0] hi;
    logic signed [DELAY_W-1:0] r;
    hi = x[PROD_W-1:DELAY_W-1];
    if ((&hi) || !(|hi)) r = x[DELAY_W-1:0];
    else if (x[PROD_W-1]) r = {1'b1, {(DELAY_W-1){1'b0}}};
    else r = {1'b0, {(DELAY_W-1){1'b1}}};
    return r;
  endfunction

endpackage

// ----- hdl/imu6lp_raw_if.sv -----
// Raw six-axis sample channel.
`timescale 1ns / 1ps
interface imu6lp_raw_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] ax_count;
  logic signed [15:0] ay_count;
  logic signed [15:0] az_count;
  logic signed [15:0] gx_count;
  logic signed [15:0] gy_count;
  logic signed [15:0] gz_count;

  modport source (output valid, ax_count, ay_count, az_count, gx_count, gy_count, gz_count,
                  input ready);
  modport sink (input valid, ax_count, ay_count, az_count, gx_count, gy_count, gz_count,
                output ready);
endinterface

// ----- hdl/imu6lp_cond_if.sv -----
// Conditioned six-axis result channel.
`timescale 1ns / 1ps
interface imu6lp_cond_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accel_x_out;
  logic signed [31:0] accel_y_out;
  logic signed [31:0] accel_z_out;
  logic signed [31:0] rate_x_out;
  logic signed [31:0] rate_y_out;
  logic signed [31:0] rate_z_out;

  modport source (output valid, accel_x_out, accel_y_out, accel_z_out,
                  rate_x_out, rate_y_out, rate_z_out, input ready);
  modport sink (input valid, accel_x_out, accel_y_out, accel_z_out,
                rate_x_out, rate_y_out, rate_z_out, output ready);
endinterface

// ----- hdl/imu6lp_cfg_if.sv -----
// Configuration register write channel.
`timescale 1ns / 1ps
interface imu6lp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/imu6lp_datapath.sv -----
// Shared-multiplier datapath: scaling, biquad, calibration, filter state and result registers.
`timescale 1ns / 1ps
module imu6lp_datapath #(
  parameter int FRAC_BITS = imu6lp_pkg::FRAC_BITS_DEF,
  parameter int RAW_BITS  = imu6lp_pkg::RAW_BITS_DEF
) (
  input  logic                                                       clk,
  input  logic                                                       rst,
  input  imu6lp_pkg::cfg_t                                           cfg,
  input  imu6lp_pkg::ctrl_t                                          ctrl,
  input  logic [imu6lp_pkg::NUM_AXES-1:0][imu6lp_pkg::CNT_W-1:0]     counts,
  output logic [imu6lp_pkg::NUM_AXES-1:0][imu6lp_pkg::OUT_W-1:0]     res_out
);

  localparam int PW = imu6lp_pkg::PROD_W;
  localparam int DW = imu6lp_pkg::DELAY_W;
  localparam int SW = imu6lp_pkg::P0S_W;
  localparam int MW = imu6lp_pkg::MUL_W;
  localparam int AW = imu6lp_pkg::AXIS_W;
  localparam int CW = imu6lp_pkg::CNT_W;
  localparam int NA = imu6lp_pkg::NUM_AXES;

  logic        [CW-1:0] cnt [NA];
  logic signed [PW-1:0] prod;
  logic signed [31:0]   v;
  logic signed [SW-1:0] p0s;
  logic signed [DW-1:0] fd [NA];
  logic signed [DW-1:0] sd [NA];
  logic        [31:0]   res [NA];

  logic [AW-1:0]        axis;
  logic                 is_gyro;
  logic [AW-1:0]        lane_w;
  logic [1:0]           lane;
  logic [CW-1:0]        cnt_sel;
  logic [31:0]          scale;
  logic [15:0]          gain;
  logic [15:0]          bias;
  logic signed [MW-1:0] a_op;
  logic signed [MW-1:0] b_op;
  logic signed [PW-1:0] fd_ext;
  logic signed [PW-1:0] sd_ext;
  logic signed [PW-1:0] p0s_ext;
  logic signed [PW-1:0] v_ext;
  logic signed [PW-1:0] bias_ext;
  logic signed [PW-1:0] y_sum;
  logic signed [PW-1:0] f1_sum;
  logic signed [PW-1:0] f2_sum;
  logic signed [PW-1:0] gyro_sum;
  logic signed [PW-1:0] p0s_full;

  always_comb begin
    axis    = ctrl.axis;
    is_gyro = (axis >= imu6lp_pkg::NUM_ACCEL);
    lane_w  = axis - (is_gyro ? imu6lp_pkg::NUM_ACCEL : AW'(0));
    lane    = lane_w[1:0];
    cnt_sel = cnt[axis];
    scale   = is_gyro ? cfg.gyro_scale : cfg.accel_scale;
    case (lane)
      2'd0:    begin gain = cfg.accel_gain[15:0];  bias = cfg.gyro_bias[15:0];  end
      2'd1:    begin gain = cfg.accel_gain[31:16]; bias = cfg.gyro_bias[31:16]; end
      default: begin gain = cfg.accel_gain[47:32]; bias = cfg.gyro_bias[47:32]; end
    endcase

    case (ctrl.uc.a_sel)
      imu6lp_pkg::A_CNT:  a_op = {{(MW-RAW_BITS){cnt_sel[RAW_BITS-1]}}, cnt_sel[RAW_BITS-1:0]};
      imu6lp_pkg::A_B0:   a_op = {2'b00, cfg.coef_b0};
      imu6lp_pkg::A_A1:   a_op = {cfg.coef_a1[31], cfg.coef_a1};
      imu6lp_pkg::A_A2:   a_op = {cfg.coef_a2[31], cfg.coef_a2};
      imu6lp_pkg::A_GAIN: a_op = {{(MW-16){1'b0}}, gain};
      default:            a_op = '0;
    endcase
    case (ctrl.uc.b_sel)
      imu6lp_pkg::B_SCALE: b_op = {1'b0, scale};
      default:             b_op = {v[31], v};
    endcase

    fd_ext   = {{(PW-DW){fd[axis][DW-1]}}, fd[axis]};
    sd_ext   = {{(PW-DW){sd[axis][DW-1]}}, sd[axis]};
    p0s_ext  = {{(PW-SW){p0s[SW-1]}}, p0s};
    v_ext    = {{(PW-32){v[31]}}, v};
    bias_ext = {{(PW-16){bias[15]}}, bias};

    // p0s holds floor(b0*v / 2^29); one more shift gives the /2^30 term
    p0s_full = prod >>> 29;
    y_sum    = (prod >>> 30) + fd_ext;
    f1_sum   = p0s_ext - (prod >>> 30) + sd_ext;
    f2_sum   = (p0s_ext >>> 1) - (prod >>> 30);
    gyro_sum = v_ext - (bias_ext <<< (FRAC_BITS - 8));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NA; i++) begin
        fd[i] <= '0;
        sd[i] <= '0;
      end
    end else begin
      case (ctrl.uc.op)
        imu6lp_pkg::OP_FILT_F1: fd[axis] <= imu6lp_pkg::sat40(f1_sum);
        imu6lp_pkg::OP_FILT_F2: sd[axis] <= imu6lp_pkg::sat40(f2_sum);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      for (int i = 0; i < NA; i++) cnt[i] <= counts[i];
    end
    if (ctrl.uc.mul_en) prod <= a_op * b_op;
    case (ctrl.uc.op)
      imu6lp_pkg::OP_LOAD_V:   v <= imu6lp_pkg::sat32(prod >>> (32 - FRAC_BITS));
      imu6lp_pkg::OP_FILT_Y: begin
        p0s <= p0s_full[SW-1:0];
        v   <= imu6lp_pkg::sat32(y_sum);
      end
      imu6lp_pkg::OP_CAL_GYRO: v <= imu6lp_pkg::sat32(gyro_sum);
      imu6lp_pkg::OP_CAL_ACC:  v <= imu6lp_pkg::sat32(prod >>> 15);
      imu6lp_pkg::OP_STORE:    res[axis] <= v;
      default: ;
    endcase
    if (ctrl.publish) begin
      for (int i = 0; i < NA; i++) res_out[i] <= res[i];
    end
  end

endmodule

// ----- hdl/imu_six_axis_lowpass_calibrate_top.sv -----
// Top level: config registers, microcode sequencer and result handshake for the IMU conditioner.
//
//  channel | role   | transaction
//  --------+--------+------------------------------------------------------------
//  raw     | sink   | six raw counts (accel x/y/z, gyro x/y/z), 16b signed
//  cond    | source | six conditioned values, Q.FRAC_BITS, 32b signed, saturated
//  cfg     | sink   | register index 0..7 and up to 48b of write data
//
//  One shared 33x33 multiplier carries every product, at most one per microcode step, so an
//  item takes 6 axes x 4..11 steps plus one publish step after accept.
//  Raw ready is high whenever the sequencer is idle and out of reset; cfg ready is high
//  outside reset.
//  Synchronous reset loads register reset values and clears the filter delays at once.
//  A result waiting on cond ready stalls only the final publish step of the next item.
`timescale 1ns / 1ps
module imu_six_axis_lowpass_calibrate_top #(
  parameter int FRAC_BITS = imu6lp_pkg::FRAC_BITS_DEF,
  parameter int RAW_BITS  = imu6lp_pkg::RAW_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  imu6lp_raw_if.sink   raw,
  imu6lp_cond_if.source cond,
  imu6lp_cfg_if.sink   cfg
);

  localparam int AW = imu6lp_pkg::AXIS_W;
  localparam int TW = imu6lp_pkg::STEP_W;

  imu6lp_pkg::cfg_t   cfg_r;
  imu6lp_pkg::ctrl_t  ctrl;
  imu6lp_pkg::ucode_t uc;

  logic          busy;
  logic [TW-1:0] step;
  logic [TW-1:0] step_next;
  logic [AW-1:0] axis;
  logic          out_valid;
  logic          accept;
  logic          take;
  logic          publish;
  logic          stall;

  logic [imu6lp_pkg::NUM_AXES-1:0][imu6lp_pkg::CNT_W-1:0] counts;
  logic [imu6lp_pkg::NUM_AXES-1:0][imu6lp_pkg::OUT_W-1:0] res_out;

  assign raw.ready  = !busy && !rst;
  assign cfg.ready  = !rst;
  assign cond.valid = out_valid;
  assign accept     = raw.valid && !busy && !rst;

  assign counts = {raw.gz_count, raw.gy_count, raw.gx_count,
                   raw.az_count, raw.ay_count, raw.ax_count};

  assign cond.accel_x_out = res_out[0];
  assign cond.accel_y_out = res_out[1];
  assign cond.accel_z_out = res_out[2];
  assign cond.rate_x_out  = res_out[3];
  assign cond.rate_y_out  = res_out[4];
  assign cond.rate_z_out  = res_out[5];

  always_comb begin
    uc = imu6lp_pkg::ucode_rom(step);
    case (uc.jmp)
      imu6lp_pkg::J_NO_FILT:   take = !cfg_r.mode[imu6lp_pkg::MODE_FILT];
      imu6lp_pkg::J_NO_CAL:    take = !cfg_r.mode[imu6lp_pkg::MODE_CAL];
      imu6lp_pkg::J_GYRO:      take = (axis >= imu6lp_pkg::NUM_ACCEL);
      imu6lp_pkg::J_ALWAYS:    take = 1'b1;
      imu6lp_pkg::J_MORE_AXES: take = (axis != imu6lp_pkg::LAST_AXIS);
      default:                 take = 1'b0;
    endcase
    step_next = take ? uc.target : step + TW'(1);
    publish   = busy && (uc.op == imu6lp_pkg::OP_PUBLISH) && (!out_valid || cond.ready);
    stall     = busy && (uc.op == imu6lp_pkg::OP_PUBLISH) && !publish;

    ctrl.uc      = busy ? uc : imu6lp_pkg::UC_IDLE;
    ctrl.axis    = axis;
    ctrl.capture = accept;
    ctrl.publish = publish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= imu6lp_pkg::ST_SCALE;
      axis      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        step <= imu6lp_pkg::ST_SCALE;
        axis <= '0;
      end else if (busy) begin
        if (publish) begin
          busy <= 1'b0;
        end else if (!stall) begin
          step <= step_next;
          if (uc.op == imu6lp_pkg::OP_STORE && take) axis <= axis + AW'(1);
        end
      end
      if (publish) out_valid <= 1'b1;
      else if (cond.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.coef_b0     <= '0;
      cfg_r.coef_a1     <= '0;
      cfg_r.coef_a2     <= '0;
      cfg_r.accel_scale <= imu6lp_pkg::ACCEL_SCALE_RST;
      cfg_r.gyro_scale  <= imu6lp_pkg::GYRO_SCALE_RST;
      cfg_r.mode        <= '0;
      cfg_r.gyro_bias   <= '0;
      cfg_r.accel_gain  <= '0;
    end else if (cfg.valid) begin
      case (imu6lp_pkg::cfg_reg_t'(cfg.index))
        imu6lp_pkg::REG_COEF_B0:     cfg_r.coef_b0     <= cfg.data[30:0];
        imu6lp_pkg::REG_COEF_A1:     cfg_r.coef_a1     <= cfg.data[31:0];
        imu6lp_pkg::REG_COEF_A2:     cfg_r.coef_a2     <= cfg.data[31:0];
        imu6lp_pkg::REG_ACCEL_SCALE: cfg_r.accel_scale <= cfg.data[31:0];
        imu6lp_pkg::REG_GYRO_SCALE:  cfg_r.gyro_scale  <= cfg.data[31:0];
        imu6lp_pkg::REG_MODE:        cfg_r.mode        <= cfg.data[1:0];
        imu6lp_pkg::REG_GYRO_BIAS:   cfg_r.gyro_bias   <= cfg.data;
        imu6lp_pkg::REG_ACCEL_GAIN:  cfg_r.accel_gain  <= cfg.data;
        default: ;
      endcase
    end
  end

  imu6lp_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .RAW_BITS  (RAW_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_r),
    .ctrl    (ctrl),
    .counts  (counts),
    .res_out (res_out)
  );

endmodule

// ----- hdl/imu6lp_checker.sv -----
// Port-level checks for the IMU conditioner, bound to the top level.
`timescale 1ns / 1ps
module imu6lp_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [191:0] out_data
);

  // result held while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // sequencer is busy with the item just taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new sample taken while sequencer busy");

  // no result can appear the cycle right after a sample is taken
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind imu_six_axis_lowpass_calibrate_top imu6lp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (raw.valid),
  .in_ready  (raw.ready),
  .out_valid (cond.valid),
  .out_ready (cond.ready),
  .out_data  ({cond.rate_z_out, cond.rate_y_out, cond.rate_x_out,
               cond.accel_z_out, cond.accel_y_out, cond.accel_x_out})
);
